// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the ordered list RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/olir_pkg.sv =====
// Types, codes and helper functions for the ordered list store.
package olir_pkg;

    localparam int DATA_W   = 32;
    localparam int POS_W    = 9;
    localparam int LEN_W    = 9;
    localparam int STATUS_W = 2;
    localparam int RADIX    = 16;
    localparam int LVL_CNT_W = 3;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                     req_type;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [STATUS_W-1:0]      status;
        logic [LEN_W-1:0]         length;
    } rsp_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic              ins_en;
        logic              rd_en;
        logic [DATA_W-1:0] value;
    } cell_cmd_t;

    // Number of registered levels in a radix-16 OR tree over n leaves.
    function automatic int tree_levels(input int n);
        int levels;
        int span;
        levels = 1;
        span   = RADIX;
        for (int k = 0; k < 8; k++) begin
            if (span < n) begin
                span   = span * RADIX;
                levels = levels + 1;
            end
        end
        return levels;
    endfunction

endpackage

// ===== rtl/core/olir_cell.sv =====
// One storage cell of the ordered list chain.
module olir_cell #(
    parameter int IDX_W = 8,
    parameter int INDEX = 0
) (
    input  logic                      clk,
    input  olir_pkg::cell_cmd_t       cmd,
    input  logic [IDX_W-1:0]          slot,
    input  logic [olir_pkg::DATA_W-1:0] prev_data,
    output logic [olir_pkg::DATA_W-1:0] data,
    output logic [olir_pkg::DATA_W-1:0] rd_data
);
    import olir_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic [DATA_W-1:0] rd_reg;
    logic [DATA_W-1:0] rd_next;

    // An insert writes the new value at the slot and moves every cell above it up by one.
    always_comb
    begin
        data_next = data_reg;
        if (cmd.ins_en)
        begin
            if (MY_IDX == slot)
            begin
                data_next = cmd.value;
            end
            else if (MY_IDX > slot)
            begin
                data_next = prev_data;
            end
        end
    end

    // Read data is held between reads so the reduction tree output stays stable.
    always_comb
    begin
        rd_next = rd_reg;
        if (cmd.rd_en)
        begin
            rd_next = (MY_IDX == slot) ? data_reg : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        rd_reg   <= rd_next;
    end

    assign data    = data_reg;
    assign rd_data = rd_reg;

endmodule

// ===== rtl/core/olir_or_tree.sv =====
// Registered radix-16 OR reduction that gathers the selected cell onto one word.
module olir_or_tree #(
    parameter int N = 256,
    parameter int W = 32
) (
    input  logic                clk,
    input  logic [N-1:0][W-1:0] leaves,
    output logic [W-1:0]        root
);
    import olir_pkg::*;

    localparam int LEVELS = tree_levels(N);
    localparam int PAD    = RADIX ** LEVELS;

    logic [W-1:0] base [PAD];
    logic [W-1:0] node_reg [LEVELS][PAD];

    for (genvar j = 0; j < PAD; j++)
    begin : g_base
        if (j < N)
        begin : g_leaf
            assign base[j] = leaves[j];
        end
        else
        begin : g_pad
            assign base[j] = '0;
        end
    end

    for (genvar k = 0; k < LEVELS; k++)
    begin : g_level
        localparam int NODES = PAD / (RADIX ** (k + 1));

        for (genvar j = 0; j < NODES; j++)
        begin : g_node
            logic [W-1:0] src [RADIX];
            logic [W-1:0] acc;

            for (genvar m = 0; m < RADIX; m++)
            begin : g_src
                if (k == 0)
                begin : g_from_base
                    assign src[m] = base[RADIX * j + m];
                end
                else
                begin : g_from_node
                    assign src[m] = node_reg[k-1][RADIX * j + m];
                end
            end

            always_comb
            begin
                acc = '0;
                for (int m = 0; m < RADIX; m++)
                begin
                    acc = acc | src[m];
                end
            end

            always_ff @(posedge clk)
            begin
                node_reg[k][j] <= acc;
            end
        end
    end

    assign root = node_reg[LEVELS-1][0];

endmodule

// ===== rtl/core/ordered_list_insert_and_read.sv =====
// Ordered list store: a shifting chain of cells with positional insert and read.
// Flow: an accepted request passes through the execute state, the read tree's registered
// levels (LEVELS is the radix-16 read tree depth, 2 at CAPACITY 256) and the result register.
// A new request is taken only once the last result is loaded; one request is in flight.
// Reset: rst_n clears the control state, the entry count and the result valid;
// cell contents stay undefined until written and are never read before that.
module ordered_list_insert_and_read #(
    parameter int CAPACITY = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  olir_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output olir_pkg::rsp_t rsp
);
    import olir_pkg::*;
    `include "assert_macros.svh"

    // Derived sizes. The compare width covers both the 9-bit position and count+1.
    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int LEVELS = tree_levels(CAPACITY);

    // The sequencer walks each request through the chain, the read tree and the
    // result register. One request is in flight at a time.
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXEC   = 4'b0010,
        S_REDUCE = 4'b0100,
        S_DONE   = 4'b1000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [LVL_CNT_W-1:0] lvl_cnt_reg;
    logic [LVL_CNT_W-1:0] lvl_cnt_next;
    req_t                 req_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [STATUS_W-1:0]  status_reg;
    logic [STATUS_W-1:0]  status_next;
    logic                 rsp_valid_reg;
    rsp_t                 rsp_reg;

    logic                 req_take;
    logic                 rsp_load;
    logic [CMP_W-1:0]     pos_x;
    logic [CMP_W-1:0]     cnt_x;
    logic                 range_err;
    logic                 full_err;
    logic                 op_ok;
    logic [IDX_W-1:0]     slot;
    cell_cmd_t            cmd;
    logic [DATA_W-1:0]    root;

    // Chain wiring: each cell sees its lower neighbor, and every cell feeds the read tree.
    logic [DATA_W-1:0]                cell_data [CAPACITY];
    logic [CAPACITY-1:0][DATA_W-1:0]  leaf;

    assign req_take = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);

    // Range and capacity checks happen in the execute cycle against the live count.
    // A range error wins over a full store.
    assign pos_x = CMP_W'(req_reg.position);
    assign cnt_x = CMP_W'(count_reg);

    always_comb
    begin
        full_err = 1'b0;
        if (req_reg.req_type == REQ_INSERT)
        begin
            range_err = (pos_x == '0) || (pos_x > cnt_x + CMP_W'(1));
            full_err  = (cnt_x == CMP_W'(CAPACITY));
        end
        else
        begin
            range_err = (pos_x == '0) || (pos_x > cnt_x);
        end
    end

    assign op_ok = !range_err && !full_err;
    assign slot  = IDX_W'(pos_x - CMP_W'(1));

    assign cmd.ins_en = (state_reg == S_EXEC) && (req_reg.req_type == REQ_INSERT) && op_ok;
    assign cmd.rd_en  = (state_reg == S_EXEC) && (req_reg.req_type == REQ_READ) && op_ok;
    assign cmd.value  = req_reg.value;

    always_comb
    begin
        count_next  = count_reg;
        status_next = status_reg;
        if (state_reg == S_EXEC)
        begin
            if (range_err)
            begin
                status_next = ST_RANGE;
            end
            else if (full_err)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                status_next = ST_OK;
            end
            if (cmd.ins_en)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    // The result register is free when empty or when its beat is taken this cycle.
    assign rsp_load = (state_reg == S_DONE) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        state_next   = state_reg;
        lvl_cnt_next = lvl_cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next   = S_REDUCE;
                lvl_cnt_next = '0;
            end
            S_REDUCE:
            begin
                if (lvl_cnt_reg == LVL_CNT_W'(LEVELS - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    lvl_cnt_next = lvl_cnt_reg + LVL_CNT_W'(1);
                end
            end
            S_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lvl_cnt_reg   <= '0;
            count_reg     <= '0;
            status_reg    <= ST_OK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            lvl_cnt_reg <= lvl_cnt_next;
            count_reg   <= count_next;
            status_reg  <= status_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: the request is captured on accept, the result when it is ready.
    // Read data is only passed on for a good read; everything else reports zero.
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            req_reg <= req;
        end
        if (rsp_load)
        begin
            rsp_reg.read_value <= (req_reg.req_type == REQ_READ && status_reg == ST_OK)
                                  ? signed'(root) : '0;
            rsp_reg.status     <= status_reg;
            rsp_reg.length     <= cnt_x[LEN_W-1:0];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] prev;

        if (i == 0)
        begin : g_first
            assign prev = '0;
        end
        else
        begin : g_rest
            assign prev = cell_data[i-1];
        end

        olir_cell #(
            .IDX_W (IDX_W),
            .INDEX (i)
        ) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .slot      (slot),
            .prev_data (prev),
            .data      (cell_data[i]),
            .rd_data   (leaf[i])
        );
    end

    olir_or_tree #(
        .N (CAPACITY),
        .W (DATA_W)
    ) u_tree (
        .clk    (clk),
        .leaves (leaf),
        .root   (root)
    );

    // The count never goes past the capacity.
    `ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(CAPACITY),
                 "entry count over capacity")
    // The count moves only by one, and only out of the execute cycle of a good insert.
    `ASSERT_NEXT(a_count_step, clk, rst_n, !cmd.ins_en, count_reg == $past(count_reg),
                 "count changed without insert")
    // A full status is only reported when the store really is full.
    `ASSERT_IMPL(a_full_status, clk, rst_n, rsp_load && status_reg == ST_FULL,
                 count_reg == CNT_W'(CAPACITY), "full status with room left")
    // No request is taken while one is still being worked on.
    `ASSERT_NEXT(a_one_in_flight, clk, rst_n, req_take, state_reg == S_EXEC,
                 "request not sent to execute")

endmodule

// ===== tb/tb_ordered_list_insert_and_read.sv =====
// Self-checking testbench for the ordered list store with positional insert and read.
module tb_ordered_list_insert_and_read;

    import olir_pkg::*;

    // The store is built at its default depth. The testbench keeps its own copy
    // of the list at the same depth, so that the full case can be reached.
    localparam int LIST_CAP     = 256;
    localparam int RANDOM_BEATS = 1400;
    localparam int INSERT_PCT   = 35;
    localparam int IDLE_PCT     = 21;
    // The drain gives any stray result beat time to show before the verdict.
    localparam int DRAIN_CYCLES = 20;
    // The worst correct run has one request in flight at a time, plus random
    // gaps on both sides. If the watchdog count reaches STUCK_LIMIT with no
    // accepted beat in between, the block has hung.
    localparam int STUCK_LIMIT  = 1000;

    // Tracks the list as the block should hold it, and the result beats that
    // are still owed, oldest first.
    class list_tracker;
        logic signed [DATA_W-1:0] entries [LIST_CAP];
        int unsigned              held;
        rsp_t                     pending_results [$];
        int                       mismatches;

        function new();
            held       = 0;
            mismatches = 0;
        endfunction

        // Applies one accepted request to the list copy and queues the
        // result beat that it must cause.
        function void note_request(input req_t r);
            rsp_t        want;
            int unsigned pos;
            pos  = r.position;
            want = '0;
            want.status = ST_OK;
            if (r.req_type == REQ_INSERT) begin
                // A range error wins over the full condition.
                if (pos == 0 || pos > held + 1) begin
                    want.status = ST_RANGE;
                end
                else if (held >= LIST_CAP) begin
                    want.status = ST_FULL;
                end
                else begin
                    for (int k = int'(held); k > int'(pos) - 1; k--) begin
                        entries[k] = entries[k-1];
                    end
                    entries[pos-1] = r.value;
                    held++;
                end
            end
            else begin
                if (pos == 0 || pos > held) begin
                    want.status = ST_RANGE;
                end
                else begin
                    want.read_value = entries[pos-1];
                end
            end
            want.length = LEN_W'(held);
            pending_results = {pending_results, want};
        endfunction

        // Compares one accepted result beat with the oldest owed beat.
        function void check_response(input rsp_t got);
            rsp_t want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result beat: read_value %0d status %0d length %0d",
                             got.read_value, got.status, got.length);
                end
                return;
            end
            want = pending_results.pop_front();
            if (got.read_value !== want.read_value || got.status !== want.status ||
                got.length !== want.length) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch exp/got: value %0d/%0d status %0d/%0d length %0d/%0d",
                             want.read_value, got.read_value, want.status, got.status,
                             want.length, got.length);
                end
            end
        endfunction

        function bit drained();
            return pending_results.size() == 0;
        endfunction
    endclass

    logic clk        = 1'b0;
    logic rst_n      = 1'b0;
    logic req_valid  = 1'b0;
    logic req_stall;
    req_t req        = '0;
    logic rsp_valid;
    logic rsp_stall  = 1'b0;
    rsp_t rsp;

    // While steady is high neither side idles, so the block sees back-to-back
    // traffic for a long stretch.
    bit          steady       = 1'b0;
    int unsigned stuck_cycles = 0;

    list_tracker sb = new();

    always #1 clk = ~clk;

    ordered_list_insert_and_read #(
        .CAPACITY (LIST_CAP)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // The receiving side stalls at random, changing only at the falling edge.
    always @(negedge clk)
    begin
        rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end

    // Result beats are taken at the rising edge. Outputs seen here still hold
    // their values from before the edge.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            sb.check_response(rsp);
        end
    end

    // The watchdog restarts on every accepted beat in either direction.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        begin
            stuck_cycles <= 0;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offers one request beat, with random idle cycles in front of it unless
    // the run is in its steady stretch. The task starts and ends at a falling
    // edge. Valid stays high from one beat to the next when no idle cycle
    // falls between them.
    task automatic send_request(input req_t r);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (req_stall);
        sb.note_request(r);
        @(negedge clk);
    endtask

    task automatic send_fields(input logic kind, input int pos, input logic [DATA_W-1:0] val);
        req_t r;
        r.req_type = kind;
        r.position = POS_W'(pos);
        r.value    = val;
        send_request(r);
    endtask

    // Lowers valid, then waits at falling edges, at least once, until every
    // owed result beat has come back.
    task automatic hold_until_drained();
        req_valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (!sb.drained());
    endtask

    // Builds a random request against the list length that the block will
    // hold when this beat arrives. Most beats are well formed; some use a
    // raw 9-bit position, which also lands on zero and far past the end.
    function automatic req_t random_request(input int insert_pct);
        req_t        r;
        int unsigned n;
        int unsigned pick;
        n    = sb.held;
        pick = $urandom_range(99);
        r.req_type = ($urandom_range(99) < insert_pct) ? REQ_INSERT : REQ_READ;
        if (pick < 12)
        begin
            r.position = POS_W'($urandom);
        end
        else if (pick < 22)
        begin
            // Boundaries: the append point, the last entry and the first one
            // past the end.
            case ($urandom_range(2))
                0: r.position = POS_W'(n);
                1: r.position = POS_W'(n + 1);
                default: r.position = POS_W'(n + 2);
            endcase
        end
        else if (r.req_type == REQ_INSERT)
        begin
            r.position = POS_W'($urandom_range(n + 1, 1));
        end
        else
        begin
            r.position = (n == 0) ? POS_W'(1) : POS_W'($urandom_range(n, 1));
        end
        if ($urandom_range(99) < 6)
        begin
            case ($urandom_range(3))
                0: r.value = 32'sh7FFF_FFFF;
                1: r.value = 32'sh8000_0000;
                2: r.value = '0;
                default: r.value = '1;
            endcase
        end
        else
        begin
            r.value = $urandom;
        end
        return r;
    endfunction

    initial
    begin
        // Reset is held low at the start and released at a falling edge.
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. Requests against an empty list are all range errors,
        // as are position zero and inserts past the append point.
        send_fields(REQ_READ,   1,   32'h0000_0000);
        send_fields(REQ_READ,   0,   32'h0000_0000);
        send_fields(REQ_INSERT, 0,   32'h1234_5678);
        send_fields(REQ_INSERT, 2,   32'h1234_5678);
        // First insert, then an append, an insert at the front and one in the
        // middle, carrying the extreme values.
        send_fields(REQ_INSERT, 1,   32'h7FFF_FFFF);
        send_fields(REQ_INSERT, 2,   32'h8000_0000);
        send_fields(REQ_INSERT, 1,   32'h0000_0000);
        send_fields(REQ_INSERT, 2,   32'hFFFF_FFFF);
        send_fields(REQ_INSERT, 511, 32'h0000_0005);
        send_fields(REQ_READ,   0,   32'h0000_0000);
        send_fields(REQ_READ,   1,   32'h0000_0000);
        send_fields(REQ_READ,   2,   32'h0000_0000);
        send_fields(REQ_READ,   3,   32'h0000_0000);
        send_fields(REQ_READ,   4,   32'h0000_0000);
        // Reads one past the end and at the highest position code.
        send_fields(REQ_READ,   5,   32'h0000_0000);
        send_fields(REQ_READ,   511, 32'hFFFF_FFFF);
        send_fields(REQ_INSERT, 6,   32'h0BAD_0BAD);
        send_fields(REQ_INSERT, 5,   32'h5555_5555);
        send_fields(REQ_READ,   5,   32'h0000_0000);
        // The value field of a read is ignored.
        send_fields(REQ_READ,   1,   32'hAAAA_AAAA);
        send_fields(REQ_INSERT, 3,   32'h0000_0001);
        send_fields(REQ_READ,   3,   32'h0000_0000);
        send_fields(REQ_READ,   6,   32'h0000_0000);

        // Random part. With this share of inserts the list fills up about
        // two thirds of the way through, so the full store and the range
        // error that outranks it both get plenty of traffic.
        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            if (i == 600)
            begin
                steady <= 1'b1;
            end
            if (i == 800)
            begin
                steady <= 1'b0;
            end
            // Now and then the sender waits for the block to empty completely.
            if (i == 300 || i == 1000)
            begin
                hold_until_drained();
            end
            send_request(random_request(INSERT_PCT));
        end

        // Wait for the last result beats, then a few more cycles to catch any
        // stray beat.
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (sb.mismatches == 0 && sb.drained())
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
